// File: rtl/core/bsoc_pkg.sv
// Shared types, widths, OCV curve and a helper function for the SOC estimator.
`timescale 1ns / 1ps

package bsoc_pkg;

    // Number of stack units that the build considers (1 keeps only the top unit).
    localparam int UNIT_COUNT   = 2;
    localparam int TABLE_POINTS = 13;

    localparam int MV_W   = 13;
    localparam int PM_W   = 10;
    localparam int SEG_W  = $clog2(TABLE_POINTS - 1);
    localparam int SUM_W  = 16;
    localparam int NUM_W  = 19;
    localparam int SCL_W  = MV_W + 4;
    localparam int SOC_W  = 26;
    localparam int MAG_W  = 50;
    localparam int MULB_W = 14;
    localparam int PROD_W = MAG_W + MULB_W;

    localparam int DIVIDEND_W = 48;
    localparam int DIVISOR_W  = 20;
    localparam int QUOT_W     = 27;
    localparam int CNT_W      = $clog2(QUOT_W + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b1;

    localparam logic [1:0] UNITS_NONE = 2'd0;
    localparam logic [1:0] UNITS_PAIR = 2'd2;

    localparam logic [SOC_W-1:0]  SOC_FULL   = 26'd65536000;
    localparam logic [MULB_W-1:0] COULOMB_K  = 14'd10000;
    localparam logic signed [32:0] STEP_POS  = 33'sd131072;
    localparam logic signed [32:0] STEP_NEG  = -33'sd131072;
    localparam logic [19:0] CAP_RESET        = 20'd25000;
    localparam logic [31:0] THR_RESET        = 32'd600000;

    localparam logic [MV_W-1:0] OCV_MV [TABLE_POINTS] = '{
        13'd2500, 13'd3080, 13'd3320, 13'd3450, 13'd3530, 13'd3590, 13'd3640,
        13'd3710, 13'd3790, 13'd3880, 13'd3990, 13'd4100, 13'd4200
    };

    localparam logic [PM_W-1:0] OCV_PM [TABLE_POINTS] = '{
        10'd0, 10'd50, 10'd100, 10'd200, 10'd300, 10'd400, 10'd500,
        10'd600, 10'd700, 10'd800, 10'd900, 10'd950, 10'd1000
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SEARCH,
        ST_OPER,
        ST_MUL,
        ST_START,
        ST_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic below;
        logic above;
        logic [SEG_W-1:0] seg;
    } ocv_seg_t;

    typedef struct packed {
        logic done;
        logic sat;
    } div_status_t;

    // Table voltage scaled by the denominator 8*n (n = 1 or 2 units).
    function automatic logic [SCL_W-1:0] ocv_scale(input logic [MV_W-1:0] mv,
                                                   input logic two);
        ocv_scale = two ? {mv, 4'b0000} : {1'b0, mv, 3'b000};
    endfunction

endpackage

// File: rtl/core/battery_soc_coulomb_ocv_estimator.sv
// Top level of the battery SOC estimator: coulomb counting with OCV re-anchoring.
`timescale 1ns / 1ps

// Channel   Signals                                          Direction
// --------  -----------------------------------------------  -----------------
// in        in_valid/in_ready, charge_*, *_stack_sum,         update word in
//           *_present, rest_time_ms
// out       out_valid/out_ready, soc_level, from_ocv          result word out
// cfg       cfg_valid/cfg_ready, cfg_index, cfg_data          register write
//
// The time from one accepted update word to the next is set by the 27 single-bit
// steps of the shared divider. It is shorter when the divider flags an oversized
// quotient, and shorter still when no division is needed (a table lookup with no
// unit or a voltage at or past a curve end, or a charge step at or past the clamp).
// Reset (rst_n, asynchronous, active low) clears the seed flag, the SOC, the
// stored charge and the two configuration registers to their defaults.
// A finished word waits in the output register, and a new update word is
// taken while it waits; the sequencer only stalls when a second result is due.

module battery_soc_coulomb_ocv_estimator (
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [31:0]             charge_whole,
    input  logic [31:0]                    charge_fraction,
    input  logic [14:0]                    top_stack_sum,
    input  logic [14:0]                    bottom_stack_sum,
    input  logic                           top_present,
    input  logic                           bottom_present,
    input  logic [31:0]                    rest_time_ms,

    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [9:0]                     soc_level,
    output logic                           from_ocv,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bsoc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bsoc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bsoc_pkg::*;

    // Sequencer.
    state_t state_reg;
    state_t state_next;
    logic   div_start;
    logic   out_load;
    logic   slot_free;
    logic   skip_div;

    // Configuration registers.
    logic [19:0] cap_reg;
    logic [31:0] thr_reg;
    logic [19:0] cap_eff;

    // Block state.
    logic             seeded_reg;
    logic [SOC_W-1:0] soc_reg;
    logic [63:0]      prev_reg;

    // Captured update word.
    logic [31:0]      cw_reg;
    logic [31:0]      cf_reg;
    logic [SUM_W-1:0] stack_sum_reg;
    logic [1:0]       unit_cnt_reg;
    logic             rest_hit_reg;
    logic [SUM_W-1:0] stack_sum_in;
    logic [1:0]       unit_cnt_in;
    logic             bottom_used;

    // Working registers.
    logic               ocv_mode_reg;
    logic signed [32:0] d_reg;
    logic [64:0]        diff_reg;
    logic [64:0]        diff_neg;
    logic [NUM_W-1:0]   num_reg;
    logic               big_pos_reg;
    logic               big_neg_reg;
    logic               neg_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               below_reg;
    logic               above_reg;
    logic [SEG_W-1:0]   seg_reg;
    logic [MAG_W-1:0]   mul_a_reg;
    logic [MULB_W-1:0]  mul_b_reg;
    logic [PROD_W-1:0]  prod;
    logic [DIVIDEND_W-1:0] dividend_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;

    // Output register.
    logic       out_valid_reg;
    logic [9:0] soc_level_reg;
    logic       from_ocv_reg;

    // Segment lookup and operand selection.
    ocv_seg_t           seg_found;
    logic               big_pos;
    logic               big_neg;
    logic               two;
    logic [SEG_W-1:0]   seg_hi;
    logic [SCL_W-1:0]   lo_scaled;
    logic [MV_W-1:0]    width_mv;
    logic [NUM_W-1:0]   offset;
    logic [PM_W-1:0]    span;

    // Divider.
    logic [QUOT_W-1:0]  quotient;
    div_status_t        div_stat;

    // Result.
    logic [PM_W-1:0]    pm_ocv;
    logic [QUOT_W:0]    ch;
    logic signed [28:0] soc_sum;
    logic [SOC_W-1:0]   soc_count;
    logic [SOC_W-1:0]   soc_new;

    // ---------------------------------------------------------------------
    // Configuration port: always ready, a write takes effect in the next cycle.
    // ---------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
            thr_reg <= THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_CAPACITY:  cap_reg <= cfg_data[19:0];
                CFG_THRESHOLD: thr_reg <= cfg_data;
                default:       cap_reg <= cap_reg;
            endcase
        end
    end

    // A capacity of zero is handled as one mAh.
    assign cap_eff = (cap_reg == '0) ? 20'd1 : cap_reg;

    // ---------------------------------------------------------------------
    // Input capture: the mean voltage is kept as the exact fraction 5*S/(8*n),
    // so only the stack sum S and the unit count n are stored.
    // ---------------------------------------------------------------------
    assign bottom_used  = (UNIT_COUNT > 1) && bottom_present;
    assign stack_sum_in = (top_present ? SUM_W'(top_stack_sum) : '0) +
                          (bottom_used ? SUM_W'(bottom_stack_sum) : '0);
    assign unit_cnt_in  = {1'b0, top_present} + {1'b0, bottom_used};

    // ---------------------------------------------------------------------
    // Sequencer.
    // ---------------------------------------------------------------------
    assign big_pos   = (d_reg >= STEP_POS);
    assign big_neg   = (d_reg <= STEP_NEG);
    assign skip_div  = ocv_mode_reg ? (seg_found.below || seg_found.above)
                                    : (big_pos || big_neg);
    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_PREP;
            ST_PREP:   state_next = ST_SEARCH;
            ST_SEARCH: state_next = skip_div ? ST_DONE : ST_OPER;
            ST_OPER:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_START;
            ST_START:  state_next = ST_WAIT;
            ST_WAIT:   if (div_stat.done) state_next = ST_DONE;
            ST_DONE:   if (slot_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:  in_ready  = 1'b1;
            ST_START: div_start = 1'b1;
            ST_DONE:  out_load  = slot_free;
            default:  in_ready  = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------------
    // OCV segment search and operand preparation. The charge step divides
    // (|dq| * 10000) >> 16 by the capacity, which equals dividing by
    // capacity << 16; interpolation divides offset * span by segment width.
    // ---------------------------------------------------------------------
    bsoc_ocv_search u_search (
        .num      (num_reg),
        .unit_cnt (unit_cnt_reg),
        .result   (seg_found)
    );

    assign diff_neg  = 65'd0 - diff_reg;
    assign two       = (unit_cnt_reg == UNITS_PAIR);
    assign seg_hi    = seg_reg + 1'b1;
    assign lo_scaled = ocv_scale(OCV_MV[seg_reg], two);
    assign width_mv  = OCV_MV[seg_hi] - OCV_MV[seg_reg];
    assign offset    = num_reg - {2'b00, lo_scaled};
    assign span      = OCV_PM[seg_hi] - OCV_PM[seg_reg];
    assign prod      = mul_a_reg * mul_b_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cw_reg        <= charge_whole;
            cf_reg        <= charge_fraction;
            stack_sum_reg <= stack_sum_in;
            unit_cnt_reg  <= unit_cnt_in;
            rest_hit_reg  <= (rest_time_ms >= thr_reg);
        end
        if (state_reg == ST_PREP)
        begin
            ocv_mode_reg <= !seeded_reg || rest_hit_reg;
            d_reg        <= $signed({cw_reg[31], cw_reg}) -
                            $signed({prev_reg[63], prev_reg[63:32]});
            diff_reg     <= {cw_reg[31], cw_reg, cf_reg} - {prev_reg[63], prev_reg};
            num_reg      <= NUM_W'({stack_sum_reg, 2'b00}) + NUM_W'(stack_sum_reg);
        end
        if (state_reg == ST_SEARCH)
        begin
            big_pos_reg <= big_pos;
            big_neg_reg <= big_neg;
            neg_reg     <= diff_reg[64];
            mag_reg     <= diff_reg[64] ? diff_neg[MAG_W-1:0] : diff_reg[MAG_W-1:0];
            below_reg   <= seg_found.below;
            above_reg   <= seg_found.above;
            seg_reg     <= seg_found.seg;
        end
        if (state_reg == ST_OPER)
        begin
            if (ocv_mode_reg)
            begin
                mul_a_reg   <= MAG_W'(offset);
                mul_b_reg   <= MULB_W'(span);
                divisor_reg <= DIVISOR_W'(ocv_scale(width_mv, two));
            end
            else
            begin
                mul_a_reg   <= mag_reg;
                mul_b_reg   <= COULOMB_K;
                divisor_reg <= cap_eff;
            end
        end
        if (state_reg == ST_MUL)
        begin
            dividend_reg <= ocv_mode_reg ? prod[DIVIDEND_W-1:0]
                                         : prod[PROD_W-1:PROD_W-DIVIDEND_W];
        end
    end

    bsoc_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .quotient (quotient),
        .status   (div_stat)
    );

    // ---------------------------------------------------------------------
    // Result: the table value replaces the counted SOC whenever this update
    // seeds or re-anchors; otherwise the charge step is added or subtracted and clamped.
    // ---------------------------------------------------------------------
    always_comb
    begin
        priority if (below_reg)
        begin
            pm_ocv = OCV_PM[0];
        end
        else if (above_reg)
        begin
            pm_ocv = OCV_PM[TABLE_POINTS-1];
        end
        else
        begin
            pm_ocv = OCV_PM[seg_reg] + PM_W'(quotient[6:0]);
        end
    end

    // An overflowing quotient stands in as 2^27, far past the clamp either way.
    assign ch      = div_stat.sat ? {1'b1, {QUOT_W{1'b0}}} : {1'b0, quotient};
    assign soc_sum = neg_reg ? ($signed({3'b000, soc_reg}) - $signed({1'b0, ch}))
                             : ($signed({3'b000, soc_reg}) + $signed({1'b0, ch}));

    always_comb
    begin
        priority if (big_pos_reg)
        begin
            soc_count = SOC_FULL;
        end
        else if (big_neg_reg)
        begin
            soc_count = '0;
        end
        else if (soc_sum < 0)
        begin
            soc_count = '0;
        end
        else if (soc_sum > $signed({3'b000, SOC_FULL}))
        begin
            soc_count = SOC_FULL;
        end
        else
        begin
            soc_count = soc_sum[SOC_W-1:0];
        end
    end

    assign soc_new = ocv_mode_reg ? {pm_ocv, 16'h0000} : soc_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
            soc_reg    <= '0;
            prev_reg   <= '0;
        end
        else if (out_load)
        begin
            seeded_reg <= 1'b1;
            soc_reg    <= soc_new;
            prev_reg   <= {cw_reg, cf_reg};
        end
    end

    // ---------------------------------------------------------------------
    // Output register.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            soc_level_reg <= soc_new[SOC_W-1:16];
            from_ocv_reg  <= ocv_mode_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign soc_level = soc_level_reg;
    assign from_ocv  = from_ocv_reg;

    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (soc_level <= 10'd1000))
        else $error("SOC word above full scale");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_WAIT))
        else $error("divider finished outside the wait state");

    a_first_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !seeded_reg) |-> ocv_mode_reg)
        else $error("first update not seeded from the OCV table");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an update is in progress");

endmodule

// File: rtl/core/bsoc_ocv_search.sv
// Segment search of the OCV curve for a mean voltage given as 5*S over 8*n.
`timescale 1ns / 1ps

module bsoc_ocv_search (
    input  logic [bsoc_pkg::NUM_W-1:0] num,
    input  logic [1:0]                 unit_cnt,
    output bsoc_pkg::ocv_seg_t         result
);
    import bsoc_pkg::*;

    logic two;
    logic none;

    assign two  = (unit_cnt == UNITS_PAIR);
    assign none = (unit_cnt == UNITS_NONE);

    // The curve is monotonic, so the last breakpoint below the voltage picks the segment.
    always_comb
    begin
        result.below = none ||
            (num <= {2'b00, ocv_scale(OCV_MV[0], two)});
        result.above = !result.below &&
            (num >= {2'b00, ocv_scale(OCV_MV[TABLE_POINTS-1], two)});
        result.seg = '0;
        for (int k = 1; k < TABLE_POINTS - 1; k++)
        begin
            if (num > {2'b00, ocv_scale(OCV_MV[k], two)})
            begin
                result.seg = SEG_W'(k);
            end
        end
    end

endmodule

// File: rtl/core/bsoc_divider.sv
// Shared restoring divider with a quotient overflow check, one bit per cycle.
`timescale 1ns / 1ps

module bsoc_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [bsoc_pkg::DIVIDEND_W-1:0] dividend,
    input  logic [bsoc_pkg::DIVISOR_W-1:0]  divisor,
    output logic [bsoc_pkg::QUOT_W-1:0]     quotient,
    output bsoc_pkg::div_status_t           status
);
    import bsoc_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic                  sat_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [QUOT_W-1:0]     work_reg;
    logic [QUOT_W-1:0]     work_next;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic [DIVISOR_W:0]    head;
    logic                  over;
    logic [DIVISOR_W+1:0]  trial;
    logic                  ge;

    // Quotient would not fit in QUOT_W bits when the top part already reaches the divisor.
    assign head = dividend[DIVIDEND_W-1:QUOT_W];
    assign over = (head >= {1'b0, divisor});

    assign trial = {1'b0, rem_reg, work_reg[QUOT_W-1]} - {2'b00, dvs_reg};
    assign ge    = !trial[DIVISOR_W+1];

    always_comb
    begin
        rem_next  = ge ? trial[DIVISOR_W-1:0] : {rem_reg[DIVISOR_W-2:0], work_reg[QUOT_W-1]};
        work_next = {work_reg[QUOT_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            sat_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= !over;
            done_reg <= over;
            sat_reg  <= over;
            cnt_reg  <= CNT_W'(QUOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= head[DIVISOR_W-1:0];
            work_reg <= dividend[QUOT_W-1:0];
            dvs_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            work_reg <= work_next;
        end
    end

    assign quotient    = work_reg;
    assign status.done = done_reg;
    assign status.sat  = sat_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < dvs_reg))
        else $error("partial remainder not below divisor");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == CNT_W'(1)) |=> (status.done && !busy_reg))
        else $error("divider did not finish after last step");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the battery SOC estimator with coulomb counting and OCV anchoring.
`timescale 1ns / 1ps

module tb_top;

    import bsoc_pkg::*;

    // One update word as the fuel gauge firmware would post it.
    typedef struct packed {
        logic [31:0] charge_whole;
        logic [31:0] charge_fraction;
        logic [14:0] top_stack_sum;
        logic [14:0] bottom_stack_sum;
        logic        top_present;
        logic        bottom_present;
        logic [31:0] rest_time_ms;
    } update_t;

    // One result word: the clamped SOC and whether it came from the OCV curve.
    typedef struct packed {
        logic [9:0] soc_level;
        logic       from_ocv;
    } soc_result_t;

    // Our own copy of the OCV curve: cell millivolts against permille.
    localparam int CURVE_LEN = 13;
    localparam bit [63:0] CURVE_MV [CURVE_LEN] = '{
        64'd2500, 64'd3080, 64'd3320, 64'd3450, 64'd3530, 64'd3590, 64'd3640,
        64'd3710, 64'd3790, 64'd3880, 64'd3990, 64'd4100, 64'd4200
    };
    localparam bit [63:0] CURVE_PM [CURVE_LEN] = '{
        64'd0, 64'd50, 64'd100, 64'd200, 64'd300, 64'd400, 64'd500,
        64'd600, 64'd700, 64'd800, 64'd900, 64'd950, 64'd1000
    };

    // A whole-unit charge jump this large pins SOC at an end without division.
    localparam longint STEP_CLAMP = 64'sd131072;
    // 1000 permille with 16 fraction bits.
    localparam longint SOC_TOP    = 64'sd65536000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic    in_valid = 1'b0;
    logic    in_ready;
    update_t offered = '0;

    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [9:0] soc_level;
    logic       from_ocv;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    // Update words waiting for the driver, and the results we expect back in order.
    update_t     update_q[$];
    soc_result_t soc_expect_q[$];

    // Words handed to the driver whose result has not come back yet. Only the
    // stimulus process raises it and only the result monitor lowers it, so a
    // zero here means the block is truly idle and safe for register writes.
    int words_open = 0;
    int mismatches = 0;
    int results_seen = 0;

    // With steady set, neither side inserts random idle gaps; the long receiver hold still applies.
    bit steady = 1'b0;

    // Predictor state: configuration mirror plus the block's own state.
    bit [19:0] pack_cap = 20'd25000;
    bit [31:0] rest_limit = 32'd600000;
    bit        gauge_seeded = 1'b0;
    longint    soc_q16 = 0;
    bit [63:0] last_charge = '0;

    // Charge value of the last generated word, so random steps stay realistic.
    bit [31:0] gauge_whole = '0;
    bit [31:0] gauge_frac = '0;

    int send_gap = 0;
    int recv_gap = 0;
    int hold_left = 0;
    int next_hold_at = 100;
    soc_result_t got_word;
    soc_result_t want_word;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    battery_soc_coulomb_ocv_estimator dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .charge_whole     (offered.charge_whole),
        .charge_fraction  (offered.charge_fraction),
        .top_stack_sum    (offered.top_stack_sum),
        .bottom_stack_sum (offered.bottom_stack_sum),
        .top_present      (offered.top_present),
        .bottom_present   (offered.bottom_present),
        .rest_time_ms     (offered.rest_time_ms),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .soc_level        (soc_level),
        .from_ocv         (from_ocv),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // Idle length between words: mostly none, often a few cycles, rarely a long gap.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Curve lookup at a cell voltage of num / den millivolts. The permille is
    // interpolated inside a segment and truncated; outside the curve the end
    // point holds, and a zero denominator (no unit fitted) reads as empty.
    function automatic bit [63:0] curve_permille(bit [63:0] num, bit [63:0] den);
        bit [63:0] lo;
        bit [63:0] hi;
        if (den == 0 || num <= CURVE_MV[0] * den)
            return CURVE_PM[0];
        if (num >= CURVE_MV[CURVE_LEN-1] * den)
            return CURVE_PM[CURVE_LEN-1];
        for (int i = 0; i + 1 < CURVE_LEN; i++)
        begin
            lo = CURVE_MV[i] * den;
            hi = CURVE_MV[i+1] * den;
            if (num >= lo && num <= hi && hi > lo)
                return CURVE_PM[i] + ((num - lo) * (CURVE_PM[i+1] - CURVE_PM[i])) / (hi - lo);
        end
        return 64'd500;
    endfunction

    // SOC anchored to the curve at the mean cell voltage of the fitted units.
    // Mean mV = sum * 10 / (16 * units), kept exact as (5 * sum) / (8 * units).
    function automatic longint anchor_soc(update_t w);
        bit [63:0] volt_sum;
        bit [63:0] units;
        volt_sum = '0;
        units = '0;
        if (w.top_present)
        begin
            volt_sum += w.top_stack_sum;
            units += 1;
        end
        if (UNIT_COUNT > 1 && w.bottom_present)
        begin
            volt_sum += w.bottom_stack_sum;
            units += 1;
        end
        return longint'(curve_permille(volt_sum * 5, units * 8)) << 16;
    endfunction

    // Next SOC for one accepted update word; advances the predictor state.
    function automatic soc_result_t advance_soc(update_t w);
        longint      now_whole;
        longint      was_whole;
        longint      step_whole;
        longint      step_q32;
        bit [63:0]   magnitude;
        bit [63:0]   divisor;
        longint      moved;
        longint      level;
        soc_result_t res;
        res.from_ocv = 1'b0;
        if (!gauge_seeded)
        begin
            // The very first word always seeds from the curve.
            soc_q16 = anchor_soc(w);
            gauge_seeded = 1'b1;
            res.from_ocv = 1'b1;
        end
        else
        begin
            now_whole = $signed(w.charge_whole);
            was_whole = $signed(last_charge[63:32]);
            step_whole = now_whole - was_whole;
            if (step_whole >= STEP_CLAMP)
                soc_q16 = SOC_TOP;
            else if (step_whole <= -STEP_CLAMP)
                soc_q16 = 0;
            else
            begin
                // Exact Q32.32 charge difference, then 10 mAh units into permille.
                step_q32 = step_whole * 64'sd4294967296
                         + longint'({32'b0, w.charge_fraction})
                         - longint'({32'b0, last_charge[31:0]});
                magnitude = (step_q32 < 0) ? -step_q32 : step_q32;
                // A capacity of zero behaves as one mAh.
                divisor = (pack_cap == 0) ? 64'd1 : {44'b0, pack_cap};
                moved = (magnitude * 64'd10000) / (divisor << 16);
                level = (step_q32 < 0) ? soc_q16 - moved : soc_q16 + moved;
                if (level < 0)
                    level = 0;
                if (level > SOC_TOP)
                    level = SOC_TOP;
                soc_q16 = level;
            end
            // Long enough at rest: trust the curve over the counted charge.
            if (w.rest_time_ms >= rest_limit)
            begin
                soc_q16 = anchor_soc(w);
                res.from_ocv = 1'b1;
            end
        end
        last_charge = {w.charge_whole, w.charge_fraction};
        if (soc_q16 > SOC_TOP)
            soc_q16 = SOC_TOP;
        res.soc_level = 10'(soc_q16 >>> 16);
        return res;
    endfunction

    // Driver: offers queued update words. Valid never waits for ready and the
    // payload is held until the word is taken. The prediction is made at the
    // very edge the word is accepted, from the payload the block sampled.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                soc_expect_q.push_back(advance_soc(offered));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (update_q.size() != 0)
                begin
                    offered <= update_q.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes result words, checks each field against the oldest
    // expectation, and decides when the receiver is ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap = 0;
            hold_left = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_word.soc_level = soc_level;
                got_word.from_ocv = from_ocv;
                if (soc_expect_q.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: soc %0d ocv %0b",
                             $time, got_word.soc_level, got_word.from_ocv);
                    mismatches++;
                end
                else
                begin
                    want_word = soc_expect_q.pop_front();
                    if (got_word.soc_level !== want_word.soc_level)
                    begin
                        $display("%0t: soc_level expected %0d actual %0d",
                                 $time, want_word.soc_level, got_word.soc_level);
                        mismatches++;
                    end
                    if (got_word.from_ocv !== want_word.from_ocv)
                    begin
                        $display("%0t: from_ocv expected %0b actual %0b",
                                 $time, want_word.from_ocv, got_word.from_ocv);
                        mismatches++;
                    end
                    words_open--;
                    results_seen++;
                end
                recv_gap = pick_gap();
            end

            // Now and then the receiver backs off for a long stretch while the
            // driver still has plenty queued, so the output register fills,
            // the block takes one more word and then has to stall its input.
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                out_ready <= 1'b0;
            end
            else if (results_seen >= next_hold_at && update_q.size() >= 20)
            begin
                hold_left = 300;
                next_hold_at = next_hold_at + 500;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap = recv_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Register write through the configuration channel; only called when idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_CAPACITY)
            pack_cap = value[19:0];
        else
            rest_limit = value;
    endtask

    task automatic add_word(input logic [31:0] whole, input logic [31:0] frac,
                            input logic [14:0] top_sum, input logic [14:0] bottom_sum,
                            input logic top_on, input logic bottom_on,
                            input logic [31:0] rest_ms);
        update_t w;
        w.charge_whole = whole;
        w.charge_fraction = frac;
        w.top_stack_sum = top_sum;
        w.bottom_stack_sum = bottom_sum;
        w.top_present = top_on;
        w.bottom_present = bottom_on;
        w.rest_time_ms = rest_ms;
        gauge_whole = whole;
        gauge_frac = frac;
        words_open++;
        update_q.push_back(w);
    endtask

    // Random update words. Charge mostly moves by small steps from the last
    // word, sometimes close to the clamp limit, and sometimes jumps anywhere.
    // Stack sums mostly land on the curve; rest time straddles the threshold.
    task automatic random_words(input int count);
        int        roll;
        int        units_step;
        bit [32:0] wide;
        logic [14:0] top_sum;
        logic [14:0] bottom_sum;
        logic [31:0] rest_ms;
        logic        top_on;
        logic        bottom_on;
        for (int k = 0; k < count; k++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 70)
                units_step = $urandom_range(0, 40);
            else if (roll < 85)
                units_step = ($urandom_range(0, 9) < 4) ? 131069 + $urandom_range(0, 6)
                                                        : $urandom_range(41, 131071);
            else
                units_step = 0;
            if ($urandom_range(0, 1))
                units_step = -units_step;
            if (roll >= 85 && roll < 93)
                gauge_whole = $urandom;
            else
                gauge_whole = gauge_whole + units_step;
            gauge_frac = $urandom;

            roll = $urandom_range(0, 9);
            top_on = (roll < 8);
            bottom_on = (roll < 6) || (roll == 8);
            top_sum = ($urandom_range(0, 99) < 85) ? 15'($urandom_range(3900, 6800))
                                                   : 15'($urandom);
            bottom_sum = ($urandom_range(0, 99) < 85) ? 15'($urandom_range(3900, 6800))
                                                      : 15'($urandom);

            roll = $urandom_range(0, 9);
            if (roll < 7 && rest_limit != 0)
                rest_ms = $urandom_range(0, rest_limit - 1);
            else if (roll < 9)
            begin
                wide = {1'b0, rest_limit} + $urandom_range(0, 2000);
                rest_ms = (wide > 33'h0FFFFFFFF) ? 32'hFFFFFFFF : wide[31:0];
            end
            else
                rest_ms = $urandom;

            add_word(gauge_whole, gauge_frac, top_sum, bottom_sum, top_on, bottom_on, rest_ms);
        end
    endtask

    // Each update word causes exactly one result, so idle means none outstanding.
    task automatic wait_idle();
        while (words_open != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input logic [31:0] capacity, input logic [31:0] threshold,
                             input int count, input bit calm);
        write_reg(CFG_CAPACITY, capacity);
        write_reg(CFG_THRESHOLD, threshold);
        steady = calm;
        random_words(count);
        wait_idle();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset configuration (25000 mAh, 600 s threshold).
        // Seed from the curve between two points.
        add_word(32'd0, 32'd0, 15'd5600, 15'd5700, 1'b1, 1'b1, 32'd0);
        // Small charge steps up and back down, rest just short of the threshold.
        add_word(32'd1, 32'h80000000, 15'd5600, 15'd5700, 1'b1, 1'b1, 32'd599999);
        add_word(32'd0, 32'd0, 15'd5600, 15'd5700, 1'b1, 1'b1, 32'd0);
        // Rest exactly at the threshold, top unit alone, on a curve point.
        add_word(32'd0, 32'd0, 15'd5744, 15'd0, 1'b1, 1'b0, 32'd600000);
        // Bottom unit alone far above the curve, rest at its maximum.
        add_word(32'd0, 32'd0, 15'd0, 15'd32767, 1'b0, 1'b1, 32'hFFFFFFFF);
        // No unit fitted: the mean voltage is empty and the curve gives zero.
        add_word(32'd0, 32'd0, 15'd5000, 15'd5000, 1'b0, 1'b0, 32'd600000);
        // Both units at zero volts, below the curve.
        add_word(32'd0, 32'd0, 15'd0, 15'd0, 1'b1, 1'b1, 32'd600000);
        // The two end points of the curve exactly.
        add_word(32'd0, 32'd0, 15'd4000, 15'd4000, 1'b1, 1'b1, 32'd600000);
        add_word(32'd0, 32'd0, 15'd6720, 15'd6720, 1'b1, 1'b1, 32'd600000);
        // Charge jumps of exactly the clamp limit, up and down.
        add_word(32'h00020000, 32'd0, 15'd5000, 15'd5000, 1'b1, 1'b1, 32'd0);
        add_word(32'd0, 32'd0, 15'd5000, 15'd5000, 1'b1, 1'b1, 32'd0);
        // One fraction short of the limit goes through the division instead.
        add_word(32'h0001FFFF, 32'hFFFFFFFF, 15'd5000, 15'd5000, 1'b1, 1'b1, 32'd0);
        // Extremes of the whole part, including the jump across the sign.
        add_word(32'h7FFFFFFF, 32'd0, 15'd5000, 15'd5000, 1'b1, 1'b1, 32'd0);
        add_word(32'h80000000, 32'd0, 15'd5000, 15'd5000, 1'b1, 1'b1, 32'd0);
        add_word(32'h7FFFFFFF, 32'hFFFFFFFF, 15'd5000, 15'd5000, 1'b1, 1'b1, 32'd0);
        add_word(32'h7FFFFFFF, 32'd0, 15'd5000, 15'd5000, 1'b1, 1'b1, 32'd0);
        // Re-anchor mid curve, then count charge in and out from there.
        add_word(32'd1000, 32'd0, 15'd5800, 15'd5800, 1'b1, 1'b1, 32'd600000);
        add_word(32'd1025, 32'd0, 15'd5800, 15'd5800, 1'b1, 1'b1, 32'd1);
        add_word(32'd990, 32'h12345678, 15'd5800, 15'd5800, 1'b1, 1'b1, 32'd599999);
        add_word(32'd990, 32'h12345678, 15'd32767, 15'd32767, 1'b1, 1'b0, 32'd599999);
        // Wide spread between the units, averaged above the curve.
        add_word(32'd990, 32'h00000001, 15'd32767, 15'd0, 1'b1, 1'b1, 32'hFFFFFFFF);
        wait_idle();

        // Random phases across the register range: the reset values written
        // back, the smallest capacity with every word re-anchoring, a zero
        // capacity with the largest threshold, the largest capacities, and a
        // spread of ordinary settings. Two phases run without random idle gaps.
        run_phase(32'd25000, 32'd600000, 220, 1'b0);
        run_phase(32'd1, 32'd0, 150, 1'b1);
        run_phase(32'd0, 32'hFFFFFFFF, 200, 1'b0);
        run_phase(32'd1000000, 32'd1000, 250, 1'b0);
        run_phase(32'h000FFFFF, $urandom, 150, 1'b1);
        run_phase($urandom_range(100, 60000), $urandom_range(0, 3000000), 380, 1'b0);

        // Allow for any stray result after the last expected one.
        repeat (60) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog: a lost result or a stuck handshake ends the run here.
    initial
    begin
        #15000000;
        $display("%0t: watchdog expired with %0d updates unanswered", $time, words_open);
        $display("tb: failure");
        $finish;
    end

endmodule
